// ===== rtl/core/sdc_pkg.sv =====
// Shared types, constants and helpers for the scaled decimal compare block.
// No dependencies; every other file in rtl/core but sdc_checker imports this package.
`timescale 1ns / 1ps

package sdc_pkg;

   localparam int WORD_W            = 32;
   localparam int MANT_W            = 3 * WORD_W;
   localparam int SCALE_W           = 8;
   localparam int CMD_W             = 3;
   localparam int DEFAULT_SCALE_CAP = 28;

   typedef enum logic [CMD_W-1:0] {
      CMD_LESS          = 3'd0,
      CMD_LESS_EQUAL    = 3'd1,
      CMD_GREATER       = 3'd2,
      CMD_GREATER_EQUAL = 3'd3,
      CMD_EQUAL         = 3'd4,
      CMD_NOT_EQUAL     = 3'd5
   } cmd_type;

   typedef struct packed {
      logic    valid;
      logic    invalid;
      logic    swapped;
      logic    a_neg;
      logic    b_neg;
      cmd_type cmd;
   } side_type;

   // upper bound on the bits of 10^n, ceil(n * log2(10)) or one more
   function automatic int scale_bits(input int n);
      return (n * 3322 + 999) / 1000;
   endfunction

endpackage

// ===== rtl/core/sdc_align.sv =====
// Entry stage: scale range check and choice of the operand to widen.
// Depends on sdc_pkg.
`timescale 1ns / 1ps

module sdc_align #(
   parameter int SCALE_CAP = sdc_pkg::DEFAULT_SCALE_CAP,
   parameter int CNT_W     = $clog2(SCALE_CAP + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [sdc_pkg::CMD_W-1:0]    command,
   input  logic [sdc_pkg::MANT_W-1:0]   a_mant,
   input  logic [sdc_pkg::SCALE_W-1:0]  a_scale,
   input  logic                         a_negative,
   input  logic [sdc_pkg::MANT_W-1:0]   b_mant,
   input  logic [sdc_pkg::SCALE_W-1:0]  b_scale,
   input  logic                         b_negative,
   output sdc_pkg::side_type            side,
   output logic [sdc_pkg::MANT_W-1:0]   small_mant,
   output logic [sdc_pkg::MANT_W-1:0]   large_mant,
   output logic [CNT_W-1:0]             cnt
);
   import sdc_pkg::*;

   localparam logic [SCALE_W-1:0] SCALE_LIMIT = SCALE_W'(SCALE_CAP);

   side_type           side_ff, side_in;
   logic [MANT_W-1:0]  small_ff, small_in, large_ff, large_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SCALE_W-1:0] diff;

   always_comb begin
      side_in.valid   = accept;
      side_in.invalid = (a_scale > SCALE_LIMIT) || (b_scale > SCALE_LIMIT);
      side_in.swapped = b_scale < a_scale;
      side_in.a_neg   = a_negative;
      side_in.b_neg   = b_negative;
      side_in.cmd     = cmd_type'(command);
      if (side_in.swapped) begin
         small_in = b_mant;
         large_in = a_mant;
         diff     = a_scale - b_scale;
      end else begin
         small_in = a_mant;
         large_in = b_mant;
         diff     = b_scale - a_scale;
      end
      cnt_in = side_in.invalid ? '0 : diff[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else begin
         side_ff <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      small_ff <= small_in;
      large_ff <= large_in;
      cnt_ff   <= cnt_in;
   end

   assign side       = side_ff;
   assign small_mant = small_ff;
   assign large_mant = large_ff;
   assign cnt        = cnt_ff;

endmodule

// ===== rtl/core/sdc_scale_stage.sv =====
// One pipeline stage of the widening chain: multiply by ten while steps remain.
// Depends on sdc_pkg.
`timescale 1ns / 1ps

module sdc_scale_stage #(
   parameter int WIDE_W = sdc_pkg::MANT_W + 4,
   parameter int CNT_W  = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sdc_pkg::side_type           side_i,
   input  logic [WIDE_W-1:0]           small_i,
   input  logic [sdc_pkg::MANT_W-1:0]  large_i,
   input  logic [CNT_W-1:0]            cnt_i,
   output sdc_pkg::side_type           side_o,
   output logic [WIDE_W-1:0]           small_o,
   output logic [sdc_pkg::MANT_W-1:0]  large_o,
   output logic [CNT_W-1:0]            cnt_o
);
   import sdc_pkg::*;

   side_type          side_ff;
   logic [WIDE_W-1:0] small_ff, small_in;
   logic [MANT_W-1:0] large_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   always_comb begin
      if (cnt_i != '0) begin
         small_in = (small_i << 3) + (small_i << 1);
         cnt_in   = cnt_i - CNT_W'(1);
      end else begin
         small_in = small_i;
         cnt_in   = cnt_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else begin
         side_ff <= side_i;
      end
   end

   always_ff @(posedge clock) begin
      small_ff <= small_in;
      large_ff <= large_i;
      cnt_ff   <= cnt_in;
   end

   assign side_o  = side_ff;
   assign small_o = small_ff;
   assign large_o = large_ff;
   assign cnt_o   = cnt_ff;

endmodule

// ===== rtl/core/sdc_order.sv =====
// Closing stages: magnitude compare, then signs, order and relation test.
// Depends on sdc_pkg.
`timescale 1ns / 1ps

module sdc_order #(
   parameter int WIDE_W = sdc_pkg::MANT_W + 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sdc_pkg::side_type           side_i,
   input  logic [WIDE_W-1:0]           small_i,
   input  logic [sdc_pkg::MANT_W-1:0]  large_i,
   output logic                        rsp_valid,
   output logic signed [1:0]           rsp_order,
   output logic                        rsp_relation_holds,
   output logic                        rsp_scale_invalid
);
   import sdc_pkg::*;

   localparam logic signed [1:0] ORD_LT = -2'sd1;
   localparam logic signed [1:0] ORD_EQ = 2'sd0;
   localparam logic signed [1:0] ORD_GT = 2'sd1;

   side_type          side_ff;
   logic              a_gt_ff, a_gt_in, a_lt_ff, a_lt_in;
   logic              a_zero_ff, a_zero_in, b_zero_ff, b_zero_in;
   logic [WIDE_W-1:0] large_wide;
   logic              small_gt, small_lt;

   logic              valid_ff;
   logic signed [1:0] order_ff, order_in;
   logic              rel_ff, rel_in;
   logic              invalid_ff;
   logic              na, nb;
   logic signed [1:0] mag;

   // compare stage
   always_comb begin
      large_wide = {{(WIDE_W - MANT_W){1'b0}}, large_i};
      small_gt   = small_i > large_wide;
      small_lt   = small_i < large_wide;
      if (side_i.swapped) begin
         a_gt_in   = small_lt;
         a_lt_in   = small_gt;
         a_zero_in = large_i == '0;
         b_zero_in = small_i == '0;
      end else begin
         a_gt_in   = small_gt;
         a_lt_in   = small_lt;
         a_zero_in = small_i == '0;
         b_zero_in = large_i == '0;
      end
   end

   // sign and relation stage
   always_comb begin
      na  = side_ff.a_neg && !a_zero_ff;
      nb  = side_ff.b_neg && !b_zero_ff;
      mag = a_gt_ff ? ORD_GT : (a_lt_ff ? ORD_LT : ORD_EQ);
      if (side_ff.invalid) begin
         order_in = ORD_EQ;
      end else if (na != nb) begin
         order_in = na ? ORD_LT : ORD_GT;
      end else begin
         order_in = na ? -mag : mag;
      end
      case (side_ff.cmd)
         CMD_LESS:          rel_in = order_in < ORD_EQ;
         CMD_LESS_EQUAL:    rel_in = order_in <= ORD_EQ;
         CMD_GREATER:       rel_in = order_in > ORD_EQ;
         CMD_GREATER_EQUAL: rel_in = order_in >= ORD_EQ;
         CMD_EQUAL:         rel_in = order_in == ORD_EQ;
         CMD_NOT_EQUAL:     rel_in = order_in != ORD_EQ;
         default:           rel_in = 1'b0;
      endcase
      if (side_ff.invalid) begin
         rel_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         side_ff  <= side_i;
         valid_ff <= side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      a_gt_ff    <= a_gt_in;
      a_lt_ff    <= a_lt_in;
      a_zero_ff  <= a_zero_in;
      b_zero_ff  <= b_zero_in;
      order_ff   <= order_in;
      rel_ff     <= rel_in;
      invalid_ff <= side_ff.invalid;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_order          = order_ff;
   assign rsp_relation_holds = rel_ff;
   assign rsp_scale_invalid  = invalid_ff;

endmodule

// ===== rtl/core/scaled_decimal_compare.sv =====
// Scaled decimal compare: three-way order of two signed 96-bit scaled decimals.
// Pipeline: one entry stage, SCALE_CAP multiply-by-ten stages and two closing stages.
// Throughput: one word per cycle; the receiver cannot stall, busy is high only in reset.
// Reset: synchronous, active high, clears every valid bit in the pipeline.
// Depends on sdc_pkg, sdc_align, sdc_scale_stage and sdc_order.
`timescale 1ns / 1ps

module scaled_decimal_compare #(
   parameter int SCALE_CAP = sdc_pkg::DEFAULT_SCALE_CAP
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [sdc_pkg::CMD_W-1:0]    req_command,
   input  logic [sdc_pkg::WORD_W-1:0]   req_a_mantissa_lo,
   input  logic [sdc_pkg::WORD_W-1:0]   req_a_mantissa_mid,
   input  logic [sdc_pkg::WORD_W-1:0]   req_a_mantissa_hi,
   input  logic [sdc_pkg::SCALE_W-1:0]  req_a_scale,
   input  logic                         req_a_negative,
   input  logic [sdc_pkg::WORD_W-1:0]   req_b_mantissa_lo,
   input  logic [sdc_pkg::WORD_W-1:0]   req_b_mantissa_mid,
   input  logic [sdc_pkg::WORD_W-1:0]   req_b_mantissa_hi,
   input  logic [sdc_pkg::SCALE_W-1:0]  req_b_scale,
   input  logic                         req_b_negative,
   output logic                         rsp_valid,
   output logic signed [1:0]            rsp_order,
   output logic                         rsp_relation_holds,
   output logic                         rsp_scale_invalid
);
   import sdc_pkg::*;

   localparam int CNT_W  = $clog2(SCALE_CAP + 1);
   localparam int WIDE_W = MANT_W + scale_bits(SCALE_CAP);

   logic                                 accept;
   side_type                             side_s  [SCALE_CAP+1];
   logic [SCALE_CAP:0][WIDE_W-1:0]       small_s;
   logic [SCALE_CAP:0][MANT_W-1:0]       large_s;
   logic [SCALE_CAP:0][CNT_W-1:0]        cnt_s;
   logic [MANT_W-1:0]                    small_0;

   assign busy   = reset;
   assign accept = start && !busy;

   sdc_align #(
      .SCALE_CAP (SCALE_CAP),
      .CNT_W     (CNT_W)
   ) u_align (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .command    (req_command),
      .a_mant     ({req_a_mantissa_hi, req_a_mantissa_mid, req_a_mantissa_lo}),
      .a_scale    (req_a_scale),
      .a_negative (req_a_negative),
      .b_mant     ({req_b_mantissa_hi, req_b_mantissa_mid, req_b_mantissa_lo}),
      .b_scale    (req_b_scale),
      .b_negative (req_b_negative),
      .side       (side_s[0]),
      .small_mant (small_0),
      .large_mant (large_s[0]),
      .cnt        (cnt_s[0])
   );

   assign small_s[0] = {{(WIDE_W - MANT_W){1'b0}}, small_0};

   for (genvar i = 0; i < SCALE_CAP; i++) begin : g_scale
      sdc_scale_stage #(
         .WIDE_W (WIDE_W),
         .CNT_W  (CNT_W)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .side_i  (side_s[i]),
         .small_i (small_s[i]),
         .large_i (large_s[i]),
         .cnt_i   (cnt_s[i]),
         .side_o  (side_s[i+1]),
         .small_o (small_s[i+1]),
         .large_o (large_s[i+1]),
         .cnt_o   (cnt_s[i+1])
      );
   end

   sdc_order #(
      .WIDE_W (WIDE_W)
   ) u_order (
      .clock              (clock),
      .reset              (reset),
      .side_i             (side_s[SCALE_CAP]),
      .small_i            (small_s[SCALE_CAP]),
      .large_i            (large_s[SCALE_CAP]),
      .rsp_valid          (rsp_valid),
      .rsp_order          (rsp_order),
      .rsp_relation_holds (rsp_relation_holds),
      .rsp_scale_invalid  (rsp_scale_invalid)
   );

endmodule

// ===== rtl/core/sdc_checker.sv =====
// Port-level checks for scaled_decimal_compare, attached by the bind below.
// Depends on scaled_decimal_compare; sees its ports only.
`timescale 1ns / 1ps

module sdc_checker #(
   parameter int LATENCY = 31
) (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_order,
   input logic       rsp_relation_holds,
   input logic       rsp_scale_invalid
);

   logic accept;
   assign accept = start && !busy;

   a_word_returns: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("accepted word gave no result");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result without an accepted word");

   a_invalid_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scale_invalid) |-> (rsp_order == 2'b00 && !rsp_relation_holds))
      else $error("invalid scale with non-zero order or relation");

   a_order_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_order != 2'b10)
      else $error("order code out of range");

endmodule

bind scaled_decimal_compare sdc_checker #(
   .LATENCY (SCALE_CAP + 3)
) u_sdc_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_order          (rsp_order),
   .rsp_relation_holds (rsp_relation_holds),
   .rsp_scale_invalid  (rsp_scale_invalid)
);
